[rtl/srpd_pkg.sv]
// ----------------------------------------------------------------------------
// srpd_pkg: shared types and constants of the scan range to point decimator
// Register map, control words between the sequencer and the serial units,
// CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package srpd_pkg;

	localparam int RANGE_W  = 16;
	localparam int ANGLE_W  = 16;
	localparam int COORD_W  = 24;
	localparam int GAP_W    = 32;
	localparam int PROD_W   = 32;
	localparam int XY_W     = 35;
	localparam int Z_W      = 24;
	localparam int DELTA_W  = 18;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int CNT_W    = 5;
	localparam int ITER_W   = 4;

	localparam int MUL_STEPS    = RANGE_W;
	localparam int CORDIC_STEPS = 16;
	localparam int SQR_STEPS    = COORD_W;

	localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic signed [COORD_W-1:0] RESET_LAST_POINT = -24'sd1024000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

	localparam logic [2:0] REG_MIN_RANGE      = 3'd0;
	localparam logic [2:0] REG_RANGE_LIMIT    = 3'd1;
	localparam logic [2:0] REG_START_ANGLE    = 3'd2;
	localparam logic [2:0] REG_ANGLE_STEP     = 3'd3;
	localparam logic [2:0] REG_SENSOR_X       = 3'd4;
	localparam logic [2:0] REG_SENSOR_Y       = 3'd5;
	localparam logic [2:0] REG_SENSOR_HEADING = 3'd6;
	localparam logic [2:0] REG_MIN_GAP_SQ     = 3'd7;

	typedef struct packed {
		logic [RANGE_W-1:0] min_range;
		logic [RANGE_W-1:0] range_limit;
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
		logic [COORD_W-1:0] sensor_x;
		logic [COORD_W-1:0] sensor_y;
		logic [ANGLE_W-1:0] sensor_heading;
		logic [GAP_W-1:0]   min_gap_sq;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              mul_step;
		logic              rot_step;
		logic              finish;
		logic [ITER_W-1:0] iter;
	} cordic_ctrl_t;

	typedef struct packed {
		logic load;
		logic step;
	} sqr_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROT,
		ST_POST,
		ST_OFFS,
		ST_DIFF,
		ST_SQR,
		ST_SUM
	} state_t;

	function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
		logic [Z_W-1:0] v;
		v = '0;
		case (i)
			4'd0:  v = 24'd2097152;
			4'd1:  v = 24'd1238021;
			4'd2:  v = 24'd654136;
			4'd3:  v = 24'd332050;
			4'd4:  v = 24'd166669;
			4'd5:  v = 24'd83416;
			4'd6:  v = 24'd41718;
			4'd7:  v = 24'd20860;
			4'd8:  v = 24'd10430;
			4'd9:  v = 24'd5215;
			4'd10: v = 24'd2608;
			4'd11: v = 24'd1304;
			4'd12: v = 24'd652;
			4'd13: v = 24'd326;
			4'd14: v = 24'd163;
			default: v = 24'd81;
		endcase
		return v;
	endfunction

endpackage

[rtl/srpd_regs.sv]
// ----------------------------------------------------------------------------
// srpd_regs: configuration register file
// APB-style slave, zero wait states, one 32-bit word per register.
// ----------------------------------------------------------------------------
module srpd_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output srpd_pkg::cfg_t cfg
);
	import srpd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_range      <= 16'd0;
			cfg_q.range_limit    <= 16'd10240;
			cfg_q.start_angle    <= 16'd0;
			cfg_q.angle_step     <= 16'd0;
			cfg_q.sensor_x       <= 24'd0;
			cfg_q.sensor_y       <= 24'd0;
			cfg_q.sensor_heading <= 16'd0;
			cfg_q.min_gap_sq     <= 32'd10486;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_RANGE:      cfg_q.min_range      <= pwdata[15:0];
				REG_RANGE_LIMIT:    cfg_q.range_limit    <= pwdata[15:0];
				REG_START_ANGLE:    cfg_q.start_angle    <= pwdata[15:0];
				REG_ANGLE_STEP:     cfg_q.angle_step     <= pwdata[15:0];
				REG_SENSOR_X:       cfg_q.sensor_x       <= pwdata[23:0];
				REG_SENSOR_Y:       cfg_q.sensor_y       <= pwdata[23:0];
				REG_SENSOR_HEADING: cfg_q.sensor_heading <= pwdata[15:0];
				default:            cfg_q.min_gap_sq     <= pwdata;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MIN_RANGE:      prdata = {16'd0, cfg_q.min_range};
			REG_RANGE_LIMIT:    prdata = {16'd0, cfg_q.range_limit};
			REG_START_ANGLE:    prdata = {16'd0, cfg_q.start_angle};
			REG_ANGLE_STEP:     prdata = {16'd0, cfg_q.angle_step};
			REG_SENSOR_X:       prdata = {8'd0, cfg_q.sensor_x};
			REG_SENSOR_Y:       prdata = {8'd0, cfg_q.sensor_y};
			REG_SENSOR_HEADING: prdata = {16'd0, cfg_q.sensor_heading};
			default:            prdata = cfg_q.min_gap_sq;
		endcase
	end

endmodule

[rtl/srpd_cordic.sv]
// ----------------------------------------------------------------------------
// srpd_cordic: polar to cartesian unit
// Bit-serial range times inverse gain, then one CORDIC rotation per cycle,
// quarter-turn fold and rounding to 1/1024 m.
// ----------------------------------------------------------------------------
module srpd_cordic (
	input  logic                                   clk,
	input  srpd_pkg::cordic_ctrl_t                 ctrl,
	input  logic [srpd_pkg::RANGE_W-1:0]           range_in,
	input  logic [srpd_pkg::ANGLE_W-1:0]           angle_in,
	output logic signed [srpd_pkg::DELTA_W-1:0]    dx,
	output logic signed [srpd_pkg::DELTA_W-1:0]    dy
);
	import srpd_pkg::*;

	logic [RANGE_W-1:0]       range_sr_q;
	logic [PROD_W-1:0]        mcand_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [1:0]               quad_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;

	logic [ANGLE_W-1:0]       a_biased;
	logic [1:0]               quad;
	logic [1:0]               res_hi;
	logic signed [XY_W-1:0]   xs, ys, tx, ty, rx, ry;
	logic [Z_W-1:0]           atan_v;

	assign a_biased = angle_in + 16'd8192;
	assign quad     = a_biased[15:14];
	assign res_hi   = angle_in[15:14] - quad;
	assign xs       = x_q >>> ctrl.iter;
	assign ys       = y_q >>> ctrl.iter;
	assign atan_v   = atan_entry(ctrl.iter);

	always_comb begin
		case (quad_q)
			2'd0: begin
				tx = x_q;
				ty = y_q;
			end
			2'd1: begin
				tx = -y_q;
				ty = x_q;
			end
			2'd2: begin
				tx = -x_q;
				ty = -y_q;
			end
			default: begin
				tx = y_q;
				ty = -x_q;
			end
		endcase
		rx = tx + 35'sd32768;
		ry = ty + 35'sd32768;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			range_sr_q <= range_in;
			mcand_q    <= {16'd0, INV_GAIN_Q16};
			x_q        <= '0;
			y_q        <= '0;
			z_q        <= {res_hi, angle_in[13:0], 8'd0};
			quad_q     <= quad;
		end else if (ctrl.mul_step) begin
			if (range_sr_q[0])
				x_q <= x_q + $signed({3'd0, mcand_q});
			range_sr_q <= range_sr_q >> 1;
			mcand_q    <= mcand_q << 1;
		end else if (ctrl.rot_step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - $signed(atan_v);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + $signed(atan_v);
			end
		end
		if (ctrl.finish) begin
			dx_q <= rx[33:16];
			dy_q <= ry[33:16];
		end
	end

	assign dx = dx_q;
	assign dy = dy_q;

endmodule

[rtl/srpd_sqr.sv]
// ----------------------------------------------------------------------------
// srpd_sqr: bit-serial squarer
// Shift-add square of a 24-bit magnitude, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module srpd_sqr (
	input  logic                          clk,
	input  srpd_pkg::sqr_ctrl_t           ctrl,
	input  logic [srpd_pkg::COORD_W-1:0]  mag,
	output logic [srpd_pkg::SQ_W-1:0]     square
);
	import srpd_pkg::*;

	logic [SQ_W-1:0]    mcand_q;
	logic [COORD_W-1:0] mplier_q;
	logic [SQ_W-1:0]    acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mcand_q  <= {{COORD_W{1'b0}}, mag};
			mplier_q <= mag;
			acc_q    <= '0;
		end else if (ctrl.step) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign square = acc_q;

endmodule

[rtl/scan_range_to_point_decimator_core.sv]
// ----------------------------------------------------------------------------
// scan_range_to_point_decimator_core: laser scan sample to decimated point
// A sample outside the range window is consumed with no word out.
// A sample inside the window runs the serial range product, 16 CORDIC
// steps, fold, offset and difference, the serial squares, then sum and
// decide, which waits while a kept point meets a stalled output.
// Reset restores the register defaults, angle 0 and last point at -1000 m.
// ----------------------------------------------------------------------------
module scan_range_to_point_decimator_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [4:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic [srpd_pkg::RANGE_W-1:0]          range_sample,
	input  logic                                  first_of_scan,
	output logic                                  point_valid,
	input  logic                                  point_stall,
	output logic signed [srpd_pkg::COORD_W-1:0]   point_x,
	output logic signed [srpd_pkg::COORD_W-1:0]   point_y
);
	import srpd_pkg::*;

	cfg_t         cfg;
	cordic_ctrl_t cordic_ctrl;
	sqr_ctrl_t    sqr_ctrl;
	state_t       state_q, state_d;

	logic [CNT_W-1:0]          cnt_q;
	logic [ANGLE_W-1:0]        beam_q;
	logic [ANGLE_W-1:0]        beam_d;
	logic [ANGLE_W-1:0]        angle;
	logic signed [COORD_W-1:0] last_x_q, last_y_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [SQ_W:0]             d2_q;
	logic signed [COORD_W-1:0] point_x_q, point_y_q;
	logic                      point_valid_q;

	logic                      accept;
	logic                      in_window;
	logic                      keep;
	logic                      decide;
	logic                      out_free;
	logic                      out_load;
	logic signed [DELTA_W-1:0] dx, dy;
	logic signed [COORD_W:0]   sum_x, sum_y;
	logic signed [COORD_W-1:0] sat_x, sat_y;
	logic signed [COORD_W:0]   ex, ey;
	logic [COORD_W-1:0]        mag_x, mag_y;
	logic [SQ_W-1:0]           sq_x, sq_y;

	srpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srpd_cordic u_cordic (
		.clk      (clk),
		.ctrl     (cordic_ctrl),
		.range_in (range_sample),
		.angle_in (angle),
		.dx       (dx),
		.dy       (dy)
	);

	srpd_sqr u_sqr_x (
		.clk    (clk),
		.ctrl   (sqr_ctrl),
		.mag    (mag_x),
		.square (sq_x)
	);

	srpd_sqr u_sqr_y (
		.clk    (clk),
		.ctrl   (sqr_ctrl),
		.mag    (mag_y),
		.square (sq_y)
	);

	assign accept    = sample_valid & ~sample_stall;
	assign in_window = (range_sample >= cfg.min_range) && (range_sample < cfg.range_limit);
	assign beam_d    = first_of_scan ? cfg.start_angle : beam_q + cfg.angle_step;
	assign angle     = beam_d + cfg.sensor_heading;
	assign keep      = d2_q > {{(SQ_W+1-GAP_W){1'b0}}, cfg.min_gap_sq};
	assign decide    = (cnt_q != '0);
	assign out_free  = ~point_valid_q | ~point_stall;

	assign sum_x = $signed({cfg.sensor_x[COORD_W-1], cfg.sensor_x})
		+ (COORD_W+1)'(dx);
	assign sum_y = $signed({cfg.sensor_y[COORD_W-1], cfg.sensor_y})
		+ (COORD_W+1)'(dy);

	always_comb begin
		sat_x = sum_x[COORD_W-1:0];
		if (sum_x[COORD_W] != sum_x[COORD_W-1])
			sat_x = sum_x[COORD_W] ? COORD_MIN : COORD_MAX;
		sat_y = sum_y[COORD_W-1:0];
		if (sum_y[COORD_W] != sum_y[COORD_W-1])
			sat_y = sum_y[COORD_W] ? COORD_MIN : COORD_MAX;
	end

	assign ex    = (COORD_W+1)'(last_x_q) - (COORD_W+1)'(px_q);
	assign ey    = (COORD_W+1)'(last_y_q) - (COORD_W+1)'(py_q);
	assign mag_x = ex[COORD_W] ? COORD_W'(-ex) : ex[COORD_W-1:0];
	assign mag_y = ey[COORD_W] ? COORD_W'(-ey) : ey[COORD_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_window)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(MUL_STEPS - 1))
					state_d = ST_ROT;
			end
			ST_ROT: begin
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
					state_d = ST_POST;
			end
			ST_POST: state_d = ST_OFFS;
			ST_OFFS: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_SQR;
			ST_SQR: begin
				if (cnt_q == CNT_W'(SQR_STEPS - 1))
					state_d = ST_SUM;
			end
			default: begin
				if (decide && (!keep || out_free))
					state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sample_stall         = (state_q != ST_IDLE);
		cordic_ctrl.load     = (state_q == ST_IDLE) && accept && in_window;
		cordic_ctrl.mul_step = (state_q == ST_MUL);
		cordic_ctrl.rot_step = (state_q == ST_ROT);
		cordic_ctrl.finish   = (state_q == ST_POST);
		cordic_ctrl.iter     = cnt_q[ITER_W-1:0];
		sqr_ctrl.load        = (state_q == ST_DIFF);
		sqr_ctrl.step        = (state_q == ST_SQR);
		out_load             = (state_q == ST_SUM) && decide && keep && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			beam_q        <= '0;
			last_x_q      <= RESET_LAST_POINT;
			last_y_q      <= RESET_LAST_POINT;
			point_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (accept) begin
				beam_q <= beam_d;
				if (first_of_scan) begin
					last_x_q <= RESET_LAST_POINT;
					last_y_q <= RESET_LAST_POINT;
				end
			end
			if (out_load) begin
				last_x_q      <= px_q;
				last_y_q      <= py_q;
				point_valid_q <= 1'b1;
			end else if (!point_stall) begin
				point_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OFFS) begin
			px_q <= sat_x;
			py_q <= sat_y;
		end
		d2_q <= {1'b0, sq_x} + {1'b0, sq_y};
		if (out_load) begin
			point_x_q <= px_q;
			point_y_q <= py_q;
		end
	end

	assign point_valid = point_valid_q;
	assign point_x     = point_x_q;
	assign point_y     = point_y_q;

endmodule
